[src/magnet_presence_debounce_alarm_macros.svh]
// Assertion macros shared by the magnet presence block.
`ifndef MAGNET_PRESENCE_DEBOUNCE_ALARM_MACROS_SVH
`define MAGNET_PRESENCE_DEBOUNCE_ALARM_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under an active-low reset.
`define MPDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define MPDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define MPDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MPDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/mpda_pkg.sv]
package mpda_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned DEBOUNCE_W = 16;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [TIME_W-1:0] LONG_ABSENCE_RESET = 32'd2000;

	typedef enum logic [1:0] {
		CODE_PRESENT = 2'd0,
		CODE_ABSENT = 2'd1,
		CODE_LONG_ABSENT = 2'd2
	} presence_code_t;

	typedef enum logic [0:0] {
		REG_DEBOUNCE_TIME = 1'b0,
		REG_LONG_ABSENCE_TIME = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic sensor_level;
		logic [TIME_W-1:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic [1:0] presence_code;
		logic alarm;
	} result_t;

endpackage

[src/magnet_presence_debounce_alarm.sv]
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+------------------------------
// sample   | sample_valid / sample_stall   | sample (sensor_level, time_ms)
// result   | result_valid / result_stall   | result (presence_code, alarm)
// config   | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item per cycle while the result side is not stalled; each item passes
// through the input register, then the result register, to the result port.
// The debounce and long-absence checks run in one pass between the two
// registers, so the tracking state is ready for the next item at once.
// Reset clears the tracking state and loads 50 ms debounce and 2000 ms
// long-absence time. A stall on the result side holds the result register
// and, while the input register holds an item, raises sample_stall at once.
`include "magnet_presence_debounce_alarm_macros.svh"

module magnet_presence_debounce_alarm
	import mpda_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input sample_t sample,
	output logic result_valid,
	input logic result_stall,
	output result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [TIME_W-1:0] cfg_data
);

	logic [DEBOUNCE_W-1:0] debounce_time_q;
	logic [TIME_W-1:0] long_absence_time_q;

	logic sample_valid_s1;
	sample_t sample_s1;
	logic result_valid_s2;
	result_t result_s2;

	logic advance;
	logic take;
	result_t result_n;

	// Configuration writes land at once; the port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q <= DEBOUNCE_RESET;
			long_absence_time_q <= LONG_ABSENCE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE_TIME: debounce_time_q <= cfg_data[DEBOUNCE_W-1:0];
				REG_LONG_ABSENCE_TIME: long_absence_time_q <= cfg_data;
			endcase
		end
	end

	// The result register moves whenever it is empty or being drained.
	assign advance = !result_valid_s2 || !result_stall;
	// Retire the item in the input register into the result register.
	assign take = sample_valid_s1 && advance;
	// Hold off new items only when the input register cannot move.
	assign sample_stall = sample_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid_s1 <= 1'b0;
			result_valid_s2 <= 1'b0;
		end else begin
			if (!sample_stall) begin
				sample_valid_s1 <= sample_valid;
			end
			if (advance) begin
				result_valid_s2 <= sample_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
		if (take) begin
			result_s2 <= result_n;
		end
	end

	// Debounce, absence timing and alarm latch; state advances on take.
	mpda_track u_track (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.sample(sample_s1),
		.debounce_time(debounce_time_q),
		.long_absence_time(long_absence_time_q),
		.result(result_n)
	);

	assign result_valid = result_valid_s2;
	assign result = result_s2;

	`MPDA_ASSERT_IMP(a_no_bad_code, clk, arst_n, result_valid_s2, result_s2.presence_code != 2'd3)
	`MPDA_ASSERT_IMP(a_long_sets_alarm, clk, arst_n, result_valid_s2 && (result_s2.presence_code == CODE_LONG_ABSENT), result_s2.alarm)
	`MPDA_ASSERT_IMP(a_present_clears_alarm, clk, arst_n, result_valid_s2 && (result_s2.presence_code == CODE_PRESENT), !result_s2.alarm)
	`MPDA_ASSERT_NXT(a_held_item_kept, clk, arst_n, sample_valid_s1 && !advance, sample_valid_s1 && result_valid_s2)

endmodule

[src/mpda_track.sv]
module mpda_track
	import mpda_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic take,
	input sample_t sample,
	input logic [DEBOUNCE_W-1:0] debounce_time,
	input logic [TIME_W-1:0] long_absence_time,
	output result_t result
);

	logic started_q;
	logic previous_level_q;
	logic [TIME_W-1:0] change_time_q;
	logic stable_away_q;
	logic [TIME_W-1:0] away_since_q;
	logic away_since_valid_q;
	logic alarm_q;

	logic level_change;
	logic [TIME_W-1:0] held_time;
	logic [TIME_W-1:0] away_time;
	logic settle;
	logic stable_away_n;
	logic away_since_valid_n;
	logic away_starts;
	logic previous_level_n;
	logic [TIME_W-1:0] change_time_n;
	logic alarm_n;
	presence_code_t code;

	always_comb begin
		level_change = sample.sensor_level != previous_level_q;
		// a fresh change has held for zero time
		held_time = level_change ? '0 : sample.time_ms - change_time_q;
		settle = held_time >= TIME_W'(debounce_time);
		change_time_n = change_time_q;
		previous_level_n = sample.sensor_level;
		stable_away_n = stable_away_q;
		away_since_valid_n = away_since_valid_q;
		away_starts = 1'b0;
		if (!started_q) begin
			stable_away_n = sample.sensor_level;
			away_since_valid_n = sample.sensor_level;
			away_starts = sample.sensor_level;
		end else begin
			if (level_change) begin
				change_time_n = sample.time_ms;
			end
			if (settle && (sample.sensor_level != stable_away_q)) begin
				stable_away_n = sample.sensor_level;
				away_since_valid_n = sample.sensor_level;
				away_starts = sample.sensor_level;
			end
		end
		// an absence that starts on this sample has lasted zero time
		away_time = away_starts ? '0 : sample.time_ms - away_since_q;
		if (started_q && stable_away_n && away_since_valid_n
				&& (away_time >= long_absence_time)) begin
			code = CODE_LONG_ABSENT;
		end else if (stable_away_n) begin
			code = CODE_ABSENT;
		end else begin
			code = CODE_PRESENT;
		end
		unique case (code)
			CODE_PRESENT: alarm_n = 1'b0;
			CODE_LONG_ABSENT: alarm_n = 1'b1;
			default: alarm_n = alarm_q;
		endcase
		result.presence_code = code;
		result.alarm = alarm_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			previous_level_q <= 1'b0;
			change_time_q <= '0;
			stable_away_q <= 1'b0;
			away_since_valid_q <= 1'b0;
			alarm_q <= 1'b0;
		end else if (take) begin
			started_q <= 1'b1;
			previous_level_q <= previous_level_n;
			change_time_q <= change_time_n;
			stable_away_q <= stable_away_n;
			away_since_valid_q <= away_since_valid_n;
			alarm_q <= alarm_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && away_starts) begin
			away_since_q <= sample.time_ms;
		end
	end

endmodule
